// ===== rtl/swsfr_pkg.sv =====
// swsfr_pkg: word types, codes and reset values for the single-wire sensor frame reader
// no dependencies; used by single_wire_sensor_frame_reader
`timescale 1ns / 1ps

package swsfr_pkg;

    typedef struct packed {
        logic opcode;
        logic pin_level;
    } t_in_word;

    typedef struct packed {
        logic        power_enable;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] reading;
    } t_out_word;

    localparam logic       OP_TICK  = 1'b0;
    localparam logic       OP_START = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PARITY  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam int         CFG_ADDR_W = 1;
    localparam int         CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_LIMIT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETTLE_TICKS  = 1'd1;

    localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd1000;
    localparam logic [7:0]  SETTLE_TICKS_RST  = 8'd5;

    localparam int          BYTE_SHIFT = 8;

endpackage

// ===== rtl/single_wire_sensor_frame_reader.sv =====
// single_wire_sensor_frame_reader: two-frame single-wire decoder, one sample word per ready cycle
// depends on swsfr_pkg (word types, status and opcode codes, config indexes)
//
//   channel   dir   handshake                 payload
//   in        in    i_in_valid / o_in_ready    i_in_word  (swsfr_pkg::t_in_word)
//   out       out   o_out_valid / i_out_ready  o_out_word (swsfr_pkg::t_out_word)
//   cfg       in    i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// one input word per cycle while o_in_ready; its result is registered in the output or skid entry
// decoder state advances through combinational logic between the input and the output register
// output register plus one skid entry: input keeps flowing while one result waits
// o_in_ready is low only while the skid entry is full
// reset is synchronous active low; config resets to timeout 1000, settle 5
`timescale 1ns / 1ps

module single_wire_sensor_frame_reader #(
    parameter int FRAME_BITS = 9
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  swsfr_pkg::t_in_word                 i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output swsfr_pkg::t_out_word                o_out_word,
    input  logic                                i_cfg_we,
    input  logic [swsfr_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [swsfr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int BC_W = $clog2(FRAME_BITS + 1);

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_SETTLE     = 3'd1;
    localparam logic [2:0] PH_FALL_START = 3'd2;
    localparam logic [2:0] PH_MEASURE    = 3'd3;
    localparam logic [2:0] PH_FALL_BIT   = 3'd4;
    localparam logic [2:0] PH_STROBE     = 3'd5;
    localparam logic [2:0] PH_RISE       = 3'd6;

    logic [15:0]           r_timeout_limit;
    logic [7:0]            r_settle_ticks;

    logic [2:0]            r_phase,      n_phase;
    logic                  r_frame,      n_frame;
    logic [BC_W-1:0]       r_bit_count,  n_bit_count;
    logic [15:0]           r_start_low,  n_start_low;
    logic [15:0]           r_wait,       n_wait;
    logic [15:0]           r_tmo_left,   n_tmo_left;
    logic [FRAME_BITS-1:0] r_frame0,     n_frame0;
    logic [FRAME_BITS-1:0] r_frame1,     n_frame1;

    logic                  r_out_valid;
    swsfr_pkg::t_out_word  r_out;
    logic                  r_skid_valid;
    swsfr_pkg::t_out_word  r_skid;

    swsfr_pkg::t_out_word  n_res;
    logic                  in_fire;
    logic                  out_free;
    logic                  spend;
    logic                  finish;
    logic [31:0]           packed_rd;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_skid_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_phase     = r_phase;
        n_frame     = r_frame;
        n_bit_count = r_bit_count;
        n_start_low = r_start_low;
        n_wait      = r_wait;
        n_tmo_left  = r_tmo_left;
        n_frame0    = r_frame0;
        n_frame1    = r_frame1;
        n_res       = '0;
        spend       = 1'b0;
        finish      = 1'b0;
        packed_rd   = '0;

        if (i_in_word.opcode == swsfr_pkg::OP_START) begin
            n_phase     = PH_SETTLE;
            n_frame     = 1'b0;
            n_frame0    = '0;
            n_frame1    = '0;
            n_bit_count = '0;
            n_start_low = '0;
            n_tmo_left  = r_timeout_limit;
            n_wait      = {8'd0, r_settle_ticks};
        end else begin
            // zero-time transitions, in the order they can chain within one sample
            if (n_phase == PH_SETTLE && n_wait == '0) begin
                n_bit_count = '0;
                n_start_low = '0;
                n_tmo_left  = r_timeout_limit;
                n_phase     = PH_FALL_START;
            end
            if (n_phase == PH_FALL_START && !i_in_word.pin_level) begin
                n_phase = PH_MEASURE;
            end
            if (n_phase == PH_MEASURE && i_in_word.pin_level) begin
                n_phase = PH_FALL_BIT;
            end
            if (n_phase == PH_FALL_BIT && !i_in_word.pin_level) begin
                n_wait  = n_start_low;
                n_phase = PH_STROBE;
            end
            if (n_phase == PH_STROBE && n_wait == '0) begin
                if (!n_frame) begin
                    n_frame0 = {n_frame0[FRAME_BITS-2:0], i_in_word.pin_level};
                end else begin
                    n_frame1 = {n_frame1[FRAME_BITS-2:0], i_in_word.pin_level};
                end
                n_phase = PH_RISE;
            end
            if (n_phase == PH_RISE && i_in_word.pin_level) begin
                n_bit_count = n_bit_count + 1'b1;
                if (n_bit_count < BC_W'(FRAME_BITS)) begin
                    n_phase = PH_FALL_BIT;
                end else if (!n_frame) begin
                    n_frame     = 1'b1;
                    n_bit_count = '0;
                    n_start_low = '0;
                    n_wait      = '0;
                    n_tmo_left  = r_timeout_limit;
                    n_phase     = PH_FALL_START;
                end else begin
                    finish         = 1'b1;
                    n_res.done_res = 1'b1;
                    if ((^n_frame0) || (^n_frame1)) begin
                        n_res.status = swsfr_pkg::ST_PARITY;
                    end else begin
                        packed_rd = (32'(n_frame0 >> 1) << swsfr_pkg::BYTE_SHIFT)
                                  | 32'(n_frame1 >> 1);
                        n_res.reading = packed_rd[15:0];
                    end
                end
            end

            // waiting phase that consumes this sample
            if (!finish) begin
                unique case (n_phase)
                    PH_IDLE: begin
                    end
                    PH_SETTLE: begin
                        n_wait = n_wait - 1'b1;
                    end
                    PH_MEASURE: begin
                        if (n_start_low != '1) begin
                            n_start_low = n_start_low + 1'b1;
                        end
                        spend = 1'b1;
                    end
                    PH_STROBE: begin
                        n_wait = n_wait - 1'b1;
                        spend  = 1'b1;
                    end
                    PH_FALL_START, PH_FALL_BIT, PH_RISE: begin
                        spend = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end

            if (spend) begin
                if (n_tmo_left <= 16'd1) begin
                    n_tmo_left     = '0;
                    n_res.done_res = 1'b1;
                    n_res.status   = swsfr_pkg::ST_TIMEOUT;
                end else begin
                    n_tmo_left = n_tmo_left - 1'b1;
                end
            end

            if (n_res.done_res) begin
                n_phase = PH_IDLE;
                if (n_res.status != swsfr_pkg::ST_OK) begin
                    n_res.reading = '0;
                end
            end
        end

        n_res.power_enable = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= swsfr_pkg::TIMEOUT_LIMIT_RST;
            r_settle_ticks  <= swsfr_pkg::SETTLE_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                swsfr_pkg::CFG_TIMEOUT_LIMIT: r_timeout_limit <= i_cfg_wdata;
                swsfr_pkg::CFG_SETTLE_TICKS:  r_settle_ticks  <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_frame     <= 1'b0;
            r_bit_count <= '0;
            r_start_low <= '0;
            r_wait      <= '0;
            r_tmo_left  <= '0;
            r_frame0    <= '0;
            r_frame1    <= '0;
        end else if (in_fire) begin
            r_phase     <= n_phase;
            r_frame     <= n_frame;
            r_bit_count <= n_bit_count;
            r_start_low <= n_start_low;
            r_wait      <= n_wait;
            r_tmo_left  <= n_tmo_left;
            r_frame0    <= n_frame0;
            r_frame1    <= n_frame1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_res;
            end
        end else if (in_fire) begin
            r_skid <= n_res;
        end
    end

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output register empty");

    a_done_powers_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.done_res) |-> !o_out_word.power_enable)
        else $error("read finished with supply still on");

    a_error_clears_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != swsfr_pkg::ST_OK)
            |-> (o_out_word.done_res && o_out_word.reading == '0))
        else $error("error word without done or with nonzero reading");

    a_start_enters_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_word.opcode == swsfr_pkg::OP_START) |=> (r_phase == PH_SETTLE))
        else $error("start word did not enter settle");

    a_idle_power_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> ((r_skid_valid ? r_skid.power_enable : r_out.power_enable)
                     == (r_phase != PH_IDLE)))
        else $error("supply drive does not follow decoder phase");
`endif

endmodule
